[hw/rtl/rsi_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rsi_pkg : ray-sphere intersection shared definitions
// Fixed-point widths, payload structs and pipeline sideband types.
// ---------------------------------------------------------------------------
package rsi_pkg;

    // coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int RAD_W       = COORD_WIDTH - 1;

    // front-end widths
    localparam int P_W  = COORD_WIDTH + 1;
    localparam int DP_W = COORD_WIDTH + P_W;
    localparam int PP_W = 2 * P_W;
    localparam int RR_W = 2 * RAD_W;
    localparam int A_W  = 2 * COORD_WIDTH;
    localparam int H_W  = 2 * COORD_WIDTH + 2;
    localparam int C_W  = 2 * COORD_WIDTH + 3;
    localparam int HM_W = H_W - 1;
    localparam int CM_W = C_W - 1;

    // limb split for the wide products
    localparam int LIMB_W  = 32;
    localparam int H_LIMBS = (HM_W + LIMB_W - 1) / LIMB_W;
    localparam int A_LIMBS = (A_W + LIMB_W - 1) / LIMB_W;
    localparam int C_LIMBS = (CM_W + LIMB_W - 1) / LIMB_W;
    localparam int HL_W    = H_LIMBS * LIMB_W;
    localparam int AL_W    = A_LIMBS * LIMB_W;
    localparam int CL_W    = C_LIMBS * LIMB_W;

    // discriminant, square root and quotient widths
    localparam int Q_W   = ((2 * HM_W > A_W + CM_W) ? 2 * HM_W : A_W + CM_W) + 2;
    localparam int H2_W  = (2 * HL_W > Q_W) ? 2 * HL_W : Q_W;
    localparam int AC_W  = (AL_W + CL_W > Q_W) ? AL_W + CL_W : Q_W;
    localparam int X_W0  = Q_W - 1 + 2 * FRAC_BITS;
    localparam int S_W   = (X_W0 + 1) / 2;
    localparam int X_W   = 2 * S_W;
    localparam int R_W   = S_W + 3;
    localparam int N_W   = ((H_W + FRAC_BITS > S_W + 1) ? H_W + FRAC_BITS : S_W + 1) + 1;
    localparam int HI_W  = N_W - COORD_WIDTH;
    localparam int DV_W  = (HI_W > A_W) ? HI_W : A_W;

    // input item
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic        [RAD_W-1:0]       radius;
    } t_ray_in;

    // result item
    typedef struct packed {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] distance;
        logic                          degenerate;
        logic                          saturated;
    } t_ray_out;

    // sideband through the product and square-root stages
    typedef struct packed {
        logic                  degen;
        logic                  miss;
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
    } t_side;

    // sideband through the divider stages
    typedef struct packed {
        logic           degen;
        logic           miss;
        logic           neg;
        logic           sat;
        logic [A_W-1:0] a;
    } t_dside;

endpackage
`default_nettype wire

[hw/rtl/ray_sphere_intersect.sv]
// Throughput: one item per cycle; busy stays low once out of reset.
// Depth is set by the bit-serial square root (one root bit per stage) and the
// restoring divider (one quotient bit per stage); the receiver cannot stall.
// Synchronous active-low reset clears every valid bit and holds busy high.
`default_nettype none
// ---------------------------------------------------------------------------
// ray_sphere_intersect : pipelined ray-sphere intersection
// Forms a, h, c and the discriminant, takes its square root and divides to
// give the nearer root in signed fixed point, with miss/degenerate/clamp flags.
// ---------------------------------------------------------------------------
module ray_sphere_intersect (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rsi_pkg::t_ray_in   i_ray,
    output logic                    o_done,
    output rsi_pkg::t_ray_out       o_result
);
    import rsi_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic accept;
    logic r_busy;

    // stage 1: offset to sphere frame
    logic                    r_s1_valid;
    logic signed [P_W-1:0]   r_s1_p [3];
    logic signed [CW-1:0]    r_s1_d [3];
    logic [RAD_W-1:0]        r_s1_rad;
    logic signed [P_W-1:0]   n_s1_p [3];

    // stage 2: narrow products
    logic                    r_s2_valid;
    logic signed [A_W-1:0]   r_s2_dd [3];
    logic signed [DP_W-1:0]  r_s2_dp [3];
    logic signed [PP_W-1:0]  r_s2_pp [3];
    logic [RR_W-1:0]         r_s2_rr;
    logic signed [A_W-1:0]   n_s2_dd [3];
    logic signed [DP_W-1:0]  n_s2_dp [3];
    logic signed [PP_W-1:0]  n_s2_pp [3];

    // stage 3: a, h, c
    logic                    r_s3_valid;
    logic [A_W-1:0]          r_s3_a;
    logic signed [H_W-1:0]   r_s3_h;
    logic signed [C_W-1:0]   r_s3_c;

    // stage 4: magnitudes
    logic                    r_s4_valid;
    t_side                   r_s4_side;
    logic [HL_W-1:0]         r_s4_hm;
    logic [AL_W-1:0]         r_s4_am;
    logic [CL_W-1:0]         r_s4_cm;
    logic                    r_s4_cneg;
    logic [H_W-1:0]          n_s4_habs;
    logic [C_W-1:0]          n_s4_cabs;

    // stage 5: limb partial products
    logic                    r_s5_valid;
    t_side                   r_s5_side;
    logic                    r_s5_cneg;
    logic [2*LIMB_W-1:0]     r_s5_ph [H_LIMBS][H_LIMBS];
    logic [2*LIMB_W-1:0]     r_s5_pa [A_LIMBS][C_LIMBS];
    logic [2*LIMB_W-1:0]     n_s5_ph [H_LIMBS][H_LIMBS];
    logic [2*LIMB_W-1:0]     n_s5_pa [A_LIMBS][C_LIMBS];

    // stage 6: row sums
    logic                    r_s6_valid;
    t_side                   r_s6_side;
    logic                    r_s6_cneg;
    logic [H2_W-1:0]         r_s6_hrow [H_LIMBS];
    logic [AC_W-1:0]         r_s6_arow [A_LIMBS];
    logic [H2_W-1:0]         n_s6_hrow [H_LIMBS];
    logic [AC_W-1:0]         n_s6_arow [A_LIMBS];

    // stage 7: full products
    logic                    r_s7_valid;
    t_side                   r_s7_side;
    logic                    r_s7_cneg;
    logic [H2_W-1:0]         r_s7_h2;
    logic [AC_W-1:0]         r_s7_ac;
    logic [H2_W-1:0]         n_s7_h2;
    logic [AC_W-1:0]         n_s7_ac;

    // discriminant and square-root pipe (index 0 is the discriminant stage)
    logic [Q_W-1:0]          n_q;
    logic                    r_sq_valid [S_W+1];
    t_side                   r_sq_side  [S_W+1];
    logic [X_W-1:0]          r_sq_x     [S_W+1];
    logic [R_W-1:0]          r_sq_rem   [S_W+1];
    logic [S_W-1:0]          r_sq_root  [S_W+1];
    logic [R_W-1:0]          n_sq_rem   [S_W];
    logic                    n_sq_fit   [S_W];

    // numerator and magnitude
    logic                    r_n1_valid;
    t_side                   r_n1_side;
    logic [N_W-1:0]          r_n1_num;
    logic                    r_n2_valid;
    t_dside                  r_n2_side;
    logic [N_W-1:0]          r_n2_mag;
    logic [DV_W-1:0]         n_hi;

    // divider pipe (index 0 is the range check stage)
    logic                    r_dv_valid [CW+1];
    t_dside                  r_dv_side  [CW+1];
    logic [A_W-1:0]          r_dv_rem   [CW+1];
    logic [CW-1:0]           r_dv_m     [CW+1];
    logic [CW-1:0]           r_dv_quo   [CW+1];
    logic [A_W:0]            n_dv_in    [CW];
    logic [A_W:0]            n_dv_diff  [CW];
    logic                    n_dv_fit   [CW];

    // output
    logic                    r_done;
    t_ray_out                r_result;
    t_ray_out                n_result;
    logic [CW-1:0]           n_lo;
    logic                    n_sat;

    // handshake: the pipe takes a transfer every cycle once out of reset
    assign accept = start & ~r_busy;
    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
            r_n1_valid <= 1'b0;
            r_n2_valid <= 1'b0;
            r_done     <= 1'b0;
            for (int k = 0; k <= S_W; k++) r_sq_valid[k] <= 1'b0;
            for (int k = 0; k <= CW; k++) r_dv_valid[k] <= 1'b0;
        end else begin
            r_s1_valid    <= accept;
            r_s2_valid    <= r_s1_valid;
            r_s3_valid    <= r_s2_valid;
            r_s4_valid    <= r_s3_valid;
            r_s5_valid    <= r_s4_valid;
            r_s6_valid    <= r_s5_valid;
            r_s7_valid    <= r_s6_valid;
            r_sq_valid[0] <= r_s7_valid;
            for (int k = 0; k < S_W; k++) r_sq_valid[k+1] <= r_sq_valid[k];
            r_n1_valid    <= r_sq_valid[S_W];
            r_n2_valid    <= r_n1_valid;
            r_dv_valid[0] <= r_n2_valid;
            for (int k = 0; k < CW; k++) r_dv_valid[k+1] <= r_dv_valid[k];
            r_done        <= r_dv_valid[CW];
        end
    end

    // stage 1: origin relative to centre
    always_comb begin
        n_s1_p[0] = {i_ray.origin_x[CW-1], i_ray.origin_x}
                  - {i_ray.center_x[CW-1], i_ray.center_x};
        n_s1_p[1] = {i_ray.origin_y[CW-1], i_ray.origin_y}
                  - {i_ray.center_y[CW-1], i_ray.center_y};
        n_s1_p[2] = {i_ray.origin_z[CW-1], i_ray.origin_z}
                  - {i_ray.center_z[CW-1], i_ray.center_z};
    end

    always_ff @(posedge i_clk) begin
        r_s1_p    <= n_s1_p;
        r_s1_d[0] <= i_ray.dir_x;
        r_s1_d[1] <= i_ray.dir_y;
        r_s1_d[2] <= i_ray.dir_z;
        r_s1_rad  <= i_ray.radius;
    end

    // stage 2: one multiplier per term
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s2_dd[k] = r_s1_d[k] * r_s1_d[k];
            n_s2_dp[k] = r_s1_d[k] * r_s1_p[k];
            n_s2_pp[k] = r_s1_p[k] * r_s1_p[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_dd <= n_s2_dd;
        r_s2_dp <= n_s2_dp;
        r_s2_pp <= n_s2_pp;
        r_s2_rr <= RR_W'(r_s1_rad) * RR_W'(r_s1_rad);
    end

    // stage 3: dot products
    always_ff @(posedge i_clk) begin
        r_s3_a <= r_s2_dd[0][A_W-1:0] + r_s2_dd[1][A_W-1:0] + r_s2_dd[2][A_W-1:0];
        r_s3_h <= H_W'(r_s2_dp[0]) + H_W'(r_s2_dp[1]) + H_W'(r_s2_dp[2]);
        r_s3_c <= C_W'(r_s2_pp[0]) + C_W'(r_s2_pp[1]) + C_W'(r_s2_pp[2])
                - C_W'(r_s2_rr);
    end

    // stage 4: sign and magnitude for the wide products
    always_comb begin
        n_s4_habs = r_s3_h[H_W-1] ? -r_s3_h : r_s3_h;
        n_s4_cabs = r_s3_c[C_W-1] ? -r_s3_c : r_s3_c;
    end

    always_ff @(posedge i_clk) begin
        r_s4_side.degen <= (r_s3_a == '0);
        r_s4_side.miss  <= 1'b0;
        r_s4_side.h     <= r_s3_h;
        r_s4_side.a     <= r_s3_a;
        r_s4_hm         <= HL_W'(n_s4_habs[HM_W-1:0]);
        r_s4_am         <= AL_W'(r_s3_a);
        r_s4_cm         <= CL_W'(n_s4_cabs[CM_W-1:0]);
        r_s4_cneg       <= r_s3_c[C_W-1];
    end

    // stage 5: 32x32 limb products of h*h and a*|c|
    always_comb begin
        for (int i = 0; i < H_LIMBS; i++) begin
            for (int j = 0; j < H_LIMBS; j++) begin
                n_s5_ph[i][j] = (2*LIMB_W)'(r_s4_hm[i*LIMB_W +: LIMB_W])
                              * (2*LIMB_W)'(r_s4_hm[j*LIMB_W +: LIMB_W]);
            end
        end
        for (int i = 0; i < A_LIMBS; i++) begin
            for (int j = 0; j < C_LIMBS; j++) begin
                n_s5_pa[i][j] = (2*LIMB_W)'(r_s4_am[i*LIMB_W +: LIMB_W])
                              * (2*LIMB_W)'(r_s4_cm[j*LIMB_W +: LIMB_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_side <= r_s4_side;
        r_s5_cneg <= r_s4_cneg;
        r_s5_ph   <= n_s5_ph;
        r_s5_pa   <= n_s5_pa;
    end

    // stage 6: sum each row of partials
    always_comb begin
        for (int i = 0; i < H_LIMBS; i++) begin
            n_s6_hrow[i] = '0;
            for (int j = 0; j < H_LIMBS; j++) begin
                n_s6_hrow[i] = n_s6_hrow[i] + (H2_W'(r_s5_ph[i][j]) << (j*LIMB_W));
            end
        end
        for (int i = 0; i < A_LIMBS; i++) begin
            n_s6_arow[i] = '0;
            for (int j = 0; j < C_LIMBS; j++) begin
                n_s6_arow[i] = n_s6_arow[i] + (AC_W'(r_s5_pa[i][j]) << (j*LIMB_W));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_side <= r_s5_side;
        r_s6_cneg <= r_s5_cneg;
        r_s6_hrow <= n_s6_hrow;
        r_s6_arow <= n_s6_arow;
    end

    // stage 7: sum the rows
    always_comb begin
        n_s7_h2 = '0;
        for (int i = 0; i < H_LIMBS; i++) begin
            n_s7_h2 = n_s7_h2 + (r_s6_hrow[i] << (i*LIMB_W));
        end
        n_s7_ac = '0;
        for (int i = 0; i < A_LIMBS; i++) begin
            n_s7_ac = n_s7_ac + (r_s6_arow[i] << (i*LIMB_W));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7_side <= r_s6_side;
        r_s7_cneg <= r_s6_cneg;
        r_s7_h2   <= n_s7_h2;
        r_s7_ac   <= n_s7_ac;
    end

    // quarter discriminant h^2 - a*c
    assign n_q = r_s7_cneg ? r_s7_h2[Q_W-1:0] + r_s7_ac[Q_W-1:0]
                           : r_s7_h2[Q_W-1:0] - r_s7_ac[Q_W-1:0];

    // square root: one root bit per stage
    always_comb begin
        logic [R_W-1:0] rem_in;
        logic [R_W-1:0] trial;
        for (int k = 0; k < S_W; k++) begin
            rem_in      = {r_sq_rem[k][R_W-3:0], r_sq_x[k][X_W-1 -: 2]};
            trial       = R_W'({r_sq_root[k], 2'b01});
            n_sq_fit[k] = (rem_in >= trial);
            n_sq_rem[k] = n_sq_fit[k] ? rem_in - trial : rem_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_side[0].degen <= r_s7_side.degen;
        r_sq_side[0].miss  <= n_q[Q_W-1];
        r_sq_side[0].h     <= r_s7_side.h;
        r_sq_side[0].a     <= r_s7_side.a;
        r_sq_x[0]          <= X_W'({n_q[Q_W-2:0], {2*FRAC_BITS{1'b0}}});
        r_sq_rem[0]        <= '0;
        r_sq_root[0]       <= '0;
        for (int k = 0; k < S_W; k++) begin
            r_sq_side[k+1] <= r_sq_side[k];
            r_sq_x[k+1]    <= r_sq_x[k] << 2;
            r_sq_rem[k+1]  <= n_sq_rem[k];
            r_sq_root[k+1] <= {r_sq_root[k][S_W-2:0], n_sq_fit[k]};
        end
    end

    // numerator -h*2^f - s, then its magnitude
    always_ff @(posedge i_clk) begin
        r_n1_side <= r_sq_side[S_W];
        r_n1_num  <= N_W'(0) - (N_W'(r_sq_side[S_W].h) << FRAC_BITS)
                   - N_W'(r_sq_root[S_W]);
        r_n2_side.degen <= r_n1_side.degen;
        r_n2_side.miss  <= r_n1_side.miss;
        r_n2_side.neg   <= r_n1_num[N_W-1];
        r_n2_side.sat   <= 1'b0;
        r_n2_side.a     <= r_n1_side.a;
        r_n2_mag        <= r_n1_num[N_W-1] ? -r_n1_num : r_n1_num;
    end

    // range check: quotient overflows when the upper part reaches a
    assign n_hi = DV_W'(r_n2_mag[N_W-1:CW]);

    // restoring division: one quotient bit per stage
    always_comb begin
        for (int k = 0; k < CW; k++) begin
            n_dv_in[k]   = {r_dv_rem[k], r_dv_m[k][CW-1]};
            n_dv_diff[k] = n_dv_in[k] - {1'b0, r_dv_side[k].a};
            n_dv_fit[k]  = (n_dv_in[k] >= {1'b0, r_dv_side[k].a});
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_side[0].degen <= r_n2_side.degen;
        r_dv_side[0].miss  <= r_n2_side.miss;
        r_dv_side[0].neg   <= r_n2_side.neg;
        r_dv_side[0].sat   <= (n_hi >= DV_W'(r_n2_side.a));
        r_dv_side[0].a     <= r_n2_side.a;
        r_dv_rem[0]        <= n_hi[A_W-1:0];
        r_dv_m[0]          <= r_n2_mag[CW-1:0];
        r_dv_quo[0]        <= '0;
        for (int k = 0; k < CW; k++) begin
            r_dv_side[k+1] <= r_dv_side[k];
            r_dv_rem[k+1]  <= n_dv_fit[k] ? n_dv_diff[k][A_W-1:0] : n_dv_in[k][A_W-1:0];
            r_dv_m[k+1]    <= r_dv_m[k] << 1;
            r_dv_quo[k+1]  <= {r_dv_quo[k][CW-2:0], n_dv_fit[k]};
        end
    end

    // clamp and format the result
    always_comb begin
        n_lo  = r_dv_quo[CW];
        n_sat = r_dv_side[CW].sat;
        if (r_dv_side[CW].neg) begin
            if (n_sat || (n_lo > {1'b1, {(CW-1){1'b0}}})) begin
                n_sat = 1'b1;
                n_lo  = {1'b1, {(CW-1){1'b0}}};
            end
        end else begin
            if (n_sat || n_lo[CW-1]) begin
                n_sat = 1'b1;
                n_lo  = {1'b0, {(CW-1){1'b1}}};
            end
        end
        n_result.hit        = 1'b1;
        n_result.distance   = r_dv_side[CW].neg ? -n_lo : n_lo;
        n_result.degenerate = 1'b0;
        n_result.saturated  = n_sat;
        if (r_dv_side[CW].degen) begin
            n_result = '0;
            n_result.degenerate = 1'b1;
        end else if (r_dv_side[CW].miss) begin
            n_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

`ifndef NO_ASSERTIONS
    // floor square root leaves a remainder no larger than twice the root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_valid[S_W] |-> (r_sq_rem[S_W] <= R_W'({r_sq_root[S_W], 1'b0})))
        else $error("square root remainder out of range");

    // divider remainder stays below the divisor when in range
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_valid[CW] && !r_dv_side[CW].sat && !r_dv_side[CW].degen)
        |-> (r_dv_rem[CW] < r_dv_side[CW].a))
        else $error("divider remainder not below divisor");

    // a zero direction is reported as a plain miss with the flag set
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.degenerate)
        |-> (!o_result.hit && !o_result.saturated && o_result.distance == '0))
        else $error("degenerate result carries hit data");

    // a miss has zero distance and no clamp
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.hit) |-> (o_result.distance == '0 && !o_result.saturated))
        else $error("miss result carries distance");
`endif

endmodule
`default_nettype wire
